FILE: rtl/core/weighted_union_find_top_macros.svh
// ----------------------------------------------------------------------------
// Weighted union-find assertion macros
// Shared assertion wrappers for the disjoint-set engine; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_UNION_FIND_TOP_MACROS_SVH
`define WEIGHTED_UNION_FIND_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define WUF_ASSERT_IMPL(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("weighted union-find assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WUF_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("weighted union-find assertion failed");

`else

`define WUF_ASSERT_IMPL(name, clock, reset, ante, cons)
`define WUF_ASSERT_NEXT(name, clock, reset, ante, cons)

`endif

`endif

FILE: rtl/core/wuf_pkg.sv
// ----------------------------------------------------------------------------
// Weighted union-find package
// Request and result types, command codes and the microcode control word.
// ----------------------------------------------------------------------------
`default_nettype none

package wuf_pkg;

  // Command codes carried in a request.
  localparam logic CMD_UNION = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // One request.
  typedef struct packed {
    logic       command;
    logic [7:0] elem_p;
    logic [7:0] elem_q;
  } wuf_req_t;

  // One result.
  typedef struct packed {
    logic       same_set;
    logic [7:0] result_root;
  } wuf_rsp_t;

  // Microprogram address.
  typedef logic [3:0] wuf_step_t;

  // Root walk operation of a step.
  typedef enum logic [2:0] {
    WALK_NONE,
    WALK_START_P,
    WALK_START_Q,
    WALK_FOLLOW_P,
    WALK_FOLLOW_Q
  } wuf_walk_t;

  // Which root the size table is read at.
  typedef enum logic {
    SIZE_AT_RP,
    SIZE_AT_RQ
  } wuf_size_sel_t;

  // Result produced by a step.
  typedef enum logic [1:0] {
    REP_NONE,
    REP_NORMAL,
    REP_BAD
  } wuf_rep_t;

  // Branch condition of a step: taken goes to the target, else to the next step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_BAD,
    COND_NOT_ROOT,
    COND_SKIP_LINK,
    COND_CLR_MORE
  } wuf_cond_t;

  // Control word driven by the sequencer into the datapath.
  typedef struct packed {
    logic          idle;
    logic          clear;
    wuf_walk_t     walk;
    wuf_size_sel_t size_sel;
    logic          load_sp;
    logic          link;
    wuf_rep_t      rep;
    wuf_cond_t     cond;
    wuf_step_t     target;
  } wuf_ctl_t;

  // Status flags returned by the datapath for branching.
  typedef struct packed {
    logic bad;
    logic not_root;
    logic skip_link;
    logic clr_more;
  } wuf_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/weighted_union_find_top.sv
// ----------------------------------------------------------------------------
// Weighted union-find engine
// Disjoint-set engine with union by size over NUM_ELEMENTS elements.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low.
// Union (command 0) joins the sets of elem_p and elem_q, placing the smaller
// tree's root under the larger one's, and a tie puts p's root under q's; query
// (command 1) changes nothing. Every request gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall it, so it must take
// it in that cycle. same_set tells whether both elements shared a root before
// the request, and result_root is the root of elem_p afterwards. An element
// index not below NUM_ELEMENTS gives same_set 0 and result_root 0 and changes
// nothing. After reset the engine clears its tables with busy high. A request
// passes a range check, walks from elem_p to its root and then from elem_q
// to its root, and for a union of two distinct roots reads both root sizes
// and links them before it reports; an out-of-range request goes from the
// range check straight to its result. Union by size keeps tree depths at most
// log2(NUM_ELEMENTS). The sequencer walks the parent table one link a cycle
// through its single read port, and busy falls in the cycle that done rises.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_union_find_top #(
  parameter int NUM_ELEMENTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire wuf_pkg::wuf_req_t request,
  output logic                   busy,
  output logic                   done,
  output wuf_pkg::wuf_rsp_t      result
);
  import wuf_pkg::*;

  wuf_ctl_t  ctl;
  wuf_stat_t stat;

  // Microprogram sequencer.
  wuf_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Tables and working registers.
  wuf_dpath #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .ctl     (ctl),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire

FILE: rtl/core/wuf_useq.sv
// ----------------------------------------------------------------------------
// Weighted union-find microsequencer
// Step counter and microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_union_find_top_macros.svh"

module wuf_useq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire wuf_pkg::wuf_stat_t stat,
  output wuf_pkg::wuf_ctl_t      ctl,
  output logic                   busy
);
  import wuf_pkg::*;

  // Microprogram addresses.
  localparam wuf_step_t S_CLEAR  = 4'd0;
  localparam wuf_step_t S_IDLE   = 4'd1;
  localparam wuf_step_t S_CHECK  = 4'd2;
  localparam wuf_step_t S_WALKP  = 4'd3;
  localparam wuf_step_t S_STARTQ = 4'd4;
  localparam wuf_step_t S_WALKQ  = 4'd5;
  localparam wuf_step_t S_SIZEP  = 4'd6;
  localparam wuf_step_t S_SIZEQ  = 4'd7;
  localparam wuf_step_t S_LINK   = 4'd8;
  localparam wuf_step_t S_REPORT = 4'd9;
  localparam wuf_step_t S_BAD    = 4'd10;

  wuf_step_t upc;
  wuf_step_t upc_next;
  logic      taken;

  // Microprogram ROM: one control word per step.
  always_comb begin
    ctl = '{idle: 1'b0, clear: 1'b0, walk: WALK_NONE, size_sel: SIZE_AT_RP,
            load_sp: 1'b0, link: 1'b0, rep: REP_NONE, cond: COND_NEVER,
            target: S_IDLE};
    case (upc)
      S_CLEAR: begin
        ctl.clear  = 1'b1;
        ctl.cond   = COND_CLR_MORE;
        ctl.target = S_CLEAR;
      end
      S_IDLE: begin
        ctl.idle   = 1'b1;
        ctl.cond   = COND_NO_START;
        ctl.target = S_IDLE;
      end
      S_CHECK: begin
        ctl.walk   = WALK_START_P;
        ctl.cond   = COND_BAD;
        ctl.target = S_BAD;
      end
      S_WALKP: begin
        ctl.walk   = WALK_FOLLOW_P;
        ctl.cond   = COND_NOT_ROOT;
        ctl.target = S_WALKP;
      end
      S_STARTQ: begin
        ctl.walk = WALK_START_Q;
      end
      S_WALKQ: begin
        ctl.walk   = WALK_FOLLOW_Q;
        ctl.cond   = COND_NOT_ROOT;
        ctl.target = S_WALKQ;
      end
      S_SIZEP: begin
        ctl.size_sel = SIZE_AT_RP;
        ctl.cond     = COND_SKIP_LINK;
        ctl.target   = S_REPORT;
      end
      S_SIZEQ: begin
        ctl.size_sel = SIZE_AT_RQ;
        ctl.load_sp  = 1'b1;
      end
      S_LINK: begin
        ctl.link = 1'b1;
      end
      S_REPORT: begin
        ctl.rep    = REP_NORMAL;
        ctl.cond   = COND_ALWAYS;
        ctl.target = S_IDLE;
      end
      S_BAD: begin
        ctl.rep    = REP_BAD;
        ctl.cond   = COND_ALWAYS;
        ctl.target = S_IDLE;
      end
      default: begin
        ctl.cond   = COND_ALWAYS;
        ctl.target = S_IDLE;
      end
    endcase
  end

  // Branch condition select.
  always_comb begin
    case (ctl.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_START:  taken = !start;
      COND_BAD:       taken = stat.bad;
      COND_NOT_ROOT:  taken = stat.not_root;
      COND_SKIP_LINK: taken = stat.skip_link;
      COND_CLR_MORE:  taken = stat.clr_more;
      default:        taken = 1'b1;
    endcase
  end

  assign upc_next = taken ? ctl.target : wuf_step_t'(upc + 4'd1);
  assign busy     = !ctl.idle;

  // Step counter; reset starts the table clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

  // A report step always returns to idle.
  `WUF_ASSERT_NEXT(a_report_to_idle, clk, rst, ctl.rep != REP_NONE, upc == S_IDLE)
  // An accepted request always enters the range check.
  `WUF_ASSERT_NEXT(a_accept_to_check, clk, rst, ctl.idle && start, upc == S_CHECK)
  // The step counter stays inside the program.
  `WUF_ASSERT_IMPL(a_upc_in_program, clk, rst, 1'b1, upc <= S_BAD)

endmodule

`default_nettype wire

FILE: rtl/core/wuf_dpath.sv
// ----------------------------------------------------------------------------
// Weighted union-find datapath
// Parent and size memories, walk pointer, root and size registers, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_union_find_top_macros.svh"

module wuf_dpath #(
  parameter int NUM_ELEMENTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire wuf_pkg::wuf_req_t request,
  input  wire wuf_pkg::wuf_ctl_t ctl,
  output wuf_pkg::wuf_stat_t     stat,
  output logic                   done,
  output wuf_pkg::wuf_rsp_t      result
);
  import wuf_pkg::*;

  localparam int IW = (NUM_ELEMENTS > 2) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int SW = $clog2(NUM_ELEMENTS + 1);

  // Tables: parent link and tree size per element.
  logic [IW-1:0] parent_mem [NUM_ELEMENTS];
  logic [SW-1:0] size_mem   [NUM_ELEMENTS];

  wuf_req_t      req;
  logic [IW-1:0] node;
  logic [IW-1:0] rp;
  logic [IW-1:0] rq;
  logic [IW-1:0] after;
  logic [SW-1:0] sp;
  logic [IW-1:0] clr;
  logic [IW-1:0] parent_rd;
  logic [SW-1:0] size_rd;

  logic [IW-1:0] idx_p;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] par_addr;
  logic [IW-1:0] sz_addr;
  logic          par_we;
  logic [IW-1:0] par_waddr;
  logic [IW-1:0] par_wdata;
  logic          sz_we;
  logic [IW-1:0] sz_waddr;
  logic [SW-1:0] sz_wdata;
  logic [SW-1:0] size_sum;
  logic          p_le_q;

  assign idx_p = IW'(req.elem_p);
  assign idx_q = IW'(req.elem_q);

  // Status for the sequencer's branches.
  assign stat.bad       = ({24'd0, req.elem_p} >= 32'(NUM_ELEMENTS))
                       || ({24'd0, req.elem_q} >= 32'(NUM_ELEMENTS));
  assign stat.not_root  = parent_rd != node;
  assign stat.skip_link = (req.command == CMD_QUERY) || (rp == rq);
  assign stat.clr_more  = clr != IW'(NUM_ELEMENTS - 1);

  // Parent read address: start of a walk, or the link just read.
  always_comb begin
    case (ctl.walk)
      WALK_START_P:  par_addr = idx_p;
      WALK_START_Q:  par_addr = idx_q;
      WALK_FOLLOW_P: par_addr = parent_rd;
      WALK_FOLLOW_Q: par_addr = parent_rd;
      default:       par_addr = node;
    endcase
  end

  assign sz_addr = (ctl.size_sel == SIZE_AT_RQ) ? rq : rp;

  // Smaller tree goes under the larger; on a tie p's root goes under q's.
  assign p_le_q   = sp <= size_rd;
  assign size_sum = SW'({1'b0, sp} + {1'b0, size_rd});

  // Table writes: the clearing pass or one link.
  assign par_we    = ctl.clear || ctl.link;
  assign par_waddr = ctl.clear ? clr : (p_le_q ? rp : rq);
  assign par_wdata = ctl.clear ? clr : (p_le_q ? rq : rp);
  assign sz_we     = ctl.clear || ctl.link;
  assign sz_waddr  = ctl.clear ? clr : (p_le_q ? rq : rp);
  assign sz_wdata  = ctl.clear ? SW'(1) : size_sum;

  // Parent memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    parent_rd <= parent_mem[par_addr];
  end

  // Size memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_waddr] <= sz_wdata;
    end
    size_rd <= size_mem[sz_addr];
  end

  // Control registers: clearing counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      done <= 1'b0;
    end else begin
      if (ctl.clear) begin
        clr <= IW'(clr + 1'b1);
      end
      done <= ctl.rep != REP_NONE;
    end
  end

  // Payload registers: request, walk pointer, roots, sizes and result.
  always_ff @(posedge clk) begin
    if (ctl.idle && start) begin
      req <= request;
    end
    case (ctl.walk)
      WALK_START_P: begin
        node <= idx_p;
      end
      WALK_START_Q: begin
        node  <= idx_q;
        after <= rp;
      end
      WALK_FOLLOW_P: begin
        node <= parent_rd;
        rp   <= node;
      end
      WALK_FOLLOW_Q: begin
        node <= parent_rd;
        rq   <= node;
      end
      default: begin
        node <= node;
      end
    endcase
    if (ctl.load_sp) begin
      sp <= size_rd;
    end
    if (ctl.link && p_le_q) begin
      after <= rq;
    end
    case (ctl.rep)
      REP_NORMAL: begin
        result.same_set    <= rp == rq;
        result.result_root <= 8'(after);
      end
      REP_BAD: begin
        result.same_set    <= 1'b0;
        result.result_root <= 8'd0;
      end
      default: begin
        result <= result;
      end
    endcase
  end

  // A link only happens for a union of two distinct roots.
  `WUF_ASSERT_IMPL(a_link_distinct, clk, rst, ctl.link, (rp != rq) && (req.command == CMD_UNION))
  // The result strobe lasts exactly one cycle.
  `WUF_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

`default_nettype wire

FILE: bench/weighted_union_find_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted union-find checker
// Keeps its own forest of parent links and tree sizes, predicts the result of
// every accepted request and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module weighted_union_find_checker
  import wuf_pkg::*;
#(
  parameter int NUM_ELEMENTS = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  wuf_req_t request,
  input  logic     done,
  input  wuf_rsp_t result,
  output int       failures,
  output int       pending
);

  // Predicted forest and the results still owed by the engine.
  int unsigned parent_link [NUM_ELEMENTS];
  int unsigned tree_weight [NUM_ELEMENTS];
  wuf_rsp_t    owed_results [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  // Follows parent links up to the root, never more steps than there are elements.
  function automatic int unsigned root_of(int unsigned node);
    int unsigned hops = 0;
    int unsigned up;
    while (hops < NUM_ELEMENTS) begin
      up = parent_link[node];
      if (up == node || up >= NUM_ELEMENTS) break;
      node = up;
      hops++;
    end
    return node;
  endfunction

  // Applies one request to the predicted forest and returns its result.
  function automatic wuf_rsp_t union_by_size(wuf_req_t req);
    wuf_rsp_t    rsp;
    int unsigned root_p;
    int unsigned root_q;
    rsp = '0;
    // An index outside the table changes nothing and reports zeros.
    if (req.elem_p >= NUM_ELEMENTS || req.elem_q >= NUM_ELEMENTS) return rsp;
    root_p = root_of(req.elem_p);
    root_q = root_of(req.elem_q);
    rsp.same_set    = (root_p == root_q);
    rsp.result_root = 8'(root_p);
    // The smaller tree goes under the larger; on a tie p's root goes under q's.
    if (req.command == CMD_UNION && !rsp.same_set) begin
      if (tree_weight[root_p] <= tree_weight[root_q]) begin
        parent_link[root_p]  = root_q;
        tree_weight[root_q] += tree_weight[root_p];
        rsp.result_root      = 8'(root_q);
      end else begin
        parent_link[root_q]  = root_p;
        tree_weight[root_p] += tree_weight[root_q];
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    failures++;
  endtask

  // Results are compared before a request in the same cycle is predicted.
  always @(posedge clk) begin
    wuf_rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
        parent_link[i] = i;
        tree_weight[i] = 1;
      end
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result same_set=%0d root=%0d with none owed",
                                    result.same_set, result.result_root));
        end else begin
          want = owed_results.pop_front();
          if (result.same_set !== want.same_set)
            report_mismatch($sformatf("same_set is %0d, predicted %0d",
                                      result.same_set, want.same_set));
          if (result.result_root !== want.result_root)
            report_mismatch($sformatf("result_root is %0d, predicted %0d",
                                      result.result_root, want.result_root));
        end
      end
      if (start && !busy) owed_results.push_back(union_by_size(request));
    end
    pending = owed_results.size();
  end

endmodule

FILE: bench/weighted_union_find_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted union-find testbench
// Drives directed and random union and query requests in bursts with gaps,
// builds balanced trees for long root walks, and leaves the
// checking to the checker module beside the engine.
// ----------------------------------------------------------------------------
module weighted_union_find_top_tb;
  import wuf_pkg::*;

  localparam int NUM_ELEMENTS = 256;
  localparam int REGION_SIZE  = 64;
  localparam int REGION_ITEMS = 165;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 30;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  wuf_req_t request;
  wuf_rsp_t result;
  int       failures;
  int       pending;

  logic     taken;
  int       quiet_cycles;
  int       burst_left;

  weighted_union_find_top #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  weighted_union_find_checker #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .failures(failures),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Marks a request accepted at the last rising edge, for the sender.
  always @(posedge clk) begin
    taken <= !rst && start && !busy;
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("no handshake for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Presents one request, waits until it is taken, then paces the next one.
  task automatic issue(logic cmd, logic [7:0] p, logic [7:0] q);
    start   <= 1'b1;
    request <= {cmd, p, q};
    do @(negedge clk); while (!taken);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      // Some bursts follow each other back to back.
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  endtask

  // Holds off new requests until every owed result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Links 16 elements pairwise, then pairs of pairs, giving a tree of depth four.
  task automatic build_balanced(int base);
    for (int stride = 1; stride < 16; stride *= 2) begin
      for (int i = 0; i < 16; i += 2 * stride) begin
        issue(CMD_UNION, 8'(base + i), 8'(base + i + stride));
      end
    end
  endtask

  initial begin
    int          base;
    int          pick;
    logic        cmd;
    logic [7:0]  p;
    logic [7:0]  q;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    taken      = 1'b0;
    quiet_cycles = 0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: element extremes, both commands, ties, joined pairs, both link directions.
    issue(CMD_QUERY, 8'd0,   8'd0);
    issue(CMD_UNION, 8'd0,   8'd0);
    issue(CMD_UNION, 8'd255, 8'd0);
    issue(CMD_UNION, 8'd0,   8'd255);
    issue(CMD_QUERY, 8'd255, 8'd0);
    issue(CMD_QUERY, 8'd255, 8'd254);
    issue(CMD_UNION, 8'd254, 8'd253);
    issue(CMD_UNION, 8'd255, 8'd253);
    issue(CMD_UNION, 8'd252, 8'd0);
    issue(CMD_UNION, 8'd255, 8'd100);
    issue(CMD_QUERY, 8'd100, 8'd252);
    issue(CMD_UNION, 8'd128, 8'd127);
    issue(CMD_UNION, 8'd127, 8'd128);
    issue(CMD_UNION, 8'd170, 8'd85);
    issue(CMD_QUERY, 8'd85,  8'd170);
    issue(CMD_UNION, 8'd85,  8'd254);
    issue(CMD_QUERY, 8'd127, 8'd255);
    drain();

    // Random: each phase grows trees inside one region, with some noise across all.
    for (int region = 0; region < NUM_ELEMENTS / REGION_SIZE; region++) begin
      base = region * REGION_SIZE;
      build_balanced(base + 16 * $urandom_range(0, 3));
      for (int n = 0; n < REGION_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          cmd = 1'($urandom_range(0, 1));
          p   = 8'($urandom_range(0, 255));
          q   = 8'($urandom_range(0, 255));
        end else begin
          cmd = ($urandom_range(0, 99) < 45) ? CMD_UNION : CMD_QUERY;
          p   = 8'(base + $urandom_range(0, REGION_SIZE - 1));
          q   = ($urandom_range(0, 7) == 0) ? p : 8'(base + $urandom_range(0, REGION_SIZE - 1));
        end
        issue(cmd, p, q);
      end
      drain();
    end

    // Let any stray result surface before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
